// ===== src/sof_pkg.sv =====
// Shared types, constants and helpers of the segment occlusion filter.
package sof_pkg;

  localparam int SofDepth = 64;
  localparam int CoordW   = 16;
  localparam int NumW     = 16;
  localparam int CntW     = $clog2(SofDepth + 1);
  localparam int DiffW    = CoordW + 1;
  localparam int ProdW    = 2 * DiffW;
  localparam int PhaseW   = 3;

  localparam logic [PhaseW-1:0] PhaseLastSign = PhaseW'(4);
  localparam logic [PhaseW-1:0] PhaseDecide   = PhaseW'(5);
  localparam logic [NumW-1:0]   NumMax        = {NumW{1'b1}};

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic                     last_in_set;
  } in_req_t;

  typedef struct packed {
    logic [NumW-1:0] segment_number;
    logic            last_of_run;
    logic            overflow;
  } out_req_t;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic [NumW-1:0]          num;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef struct packed {
    logic pos;
    logic neg;
  } sign_t;

  typedef enum logic [1:0] {
    StIdle,
    StTest,
    StAppend,
    StEmit
  } state_e;

  function automatic logic ranges_meet(input logic signed [CoordW-1:0] a0,
                                       input logic signed [CoordW-1:0] a1,
                                       input logic signed [CoordW-1:0] b0,
                                       input logic signed [CoordW-1:0] b1);
    logic signed [CoordW-1:0] alo, ahi, blo, bhi;
    alo = (a0 < a1) ? a0 : a1;
    ahi = (a0 < a1) ? a1 : a0;
    blo = (b0 < b1) ? b0 : b1;
    bhi = (b0 < b1) ? b1 : b0;
    return (alo <= bhi) && (blo <= ahi);
  endfunction

endpackage

// ===== src/sof_cell.sv =====
// One list cell: holds a kept segment and its number, shifts toward the head.
module sof_cell (
  input  logic              clk_i,
  input  sof_pkg::cell_ctl_t ctl_i,
  input  sof_pkg::entry_t   ld_data_i,
  input  sof_pkg::entry_t   nb_data_i,
  output sof_pkg::entry_t   data_o
);

  sof_pkg::entry_t data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      data_q <= ld_data_i;
    end else if (ctl_i.shift) begin
      data_q <= nb_data_i;
    end
  end

  assign data_o = data_q;

endmodule

// ===== src/sof_orient.sv =====
// Shared orientation unit: registered cross products, then sign of their difference.
module sof_orient (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [sof_pkg::CoordW-1:0] px_i,
  input  logic signed [sof_pkg::CoordW-1:0] py_i,
  input  logic signed [sof_pkg::CoordW-1:0] qx_i,
  input  logic signed [sof_pkg::CoordW-1:0] qy_i,
  input  logic signed [sof_pkg::CoordW-1:0] rx_i,
  input  logic signed [sof_pkg::CoordW-1:0] ry_i,
  output sof_pkg::sign_t                   sign_o
);

  logic signed [sof_pkg::DiffW-1:0] dqx, dry, dqy, drx;
  logic signed [sof_pkg::ProdW-1:0] p1_q, p2_q;
  logic signed [sof_pkg::ProdW:0]   diff;

  assign dqx = sof_pkg::DiffW'(qx_i) - sof_pkg::DiffW'(px_i);
  assign dry = sof_pkg::DiffW'(ry_i) - sof_pkg::DiffW'(qy_i);
  assign dqy = sof_pkg::DiffW'(qy_i) - sof_pkg::DiffW'(py_i);
  assign drx = sof_pkg::DiffW'(rx_i) - sof_pkg::DiffW'(qx_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q <= dqx * dry;
      p2_q <= dqy * drx;
    end
  end

  assign diff       = (sof_pkg::ProdW+1)'(p1_q) - (sof_pkg::ProdW+1)'(p2_q);
  assign sign_o.neg = diff[sof_pkg::ProdW];
  assign sign_o.pos = !diff[sof_pkg::ProdW] && (diff != '0);

endmodule

// ===== src/segment_occlusion_filter_top.sv =====
// Top level of the segment occlusion filter: cell chain, orientation unit, control.
// A segment is tested against the k segments in the kept list in turn: each kept
// segment leaves the head cell, goes through the one shared orientation unit in
// six steps (four orientations through a registered multiplier pair, then the
// keep/drop decision) and re-enters the chain behind the others if it survives;
// StIdle accepts and StAppend appends. The last segment of a set then reads the
// list out from the head cell, one number per cycle while the output is taken.
module segment_occlusion_filter_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sof_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sof_pkg::out_req_t out_req_o
);

  sof_pkg::state_e state_q, state_d;
  logic [sof_pkg::CntW-1:0]   len_q, len_d, rem_q, rem_d;
  logic [sof_pkg::NumW-1:0]   arr_q, arr_d;
  logic                       ovf_q, ovf_d;
  logic [sof_pkg::PhaseW-1:0] phase_q, phase_d;
  sof_pkg::entry_t            seg_q;
  logic                       last_q;
  sof_pkg::sign_t             sgn_q [4];
  logic                       out_valid_q, out_valid_d;
  sof_pkg::out_req_t          out_q, out_d;

  sof_pkg::entry_t   cell_data [sof_pkg::SofDepth];
  sof_pkg::entry_t   ld_data;
  logic              shift_en, load_en;
  logic [sof_pkg::CntW-1:0] load_idx;

  logic in_acc, emit_go, touch, all_zero, side12, side34;
  sof_pkg::entry_t head;
  logic signed [sof_pkg::CoordW-1:0] px, py, qx, qy, rx, ry;
  sof_pkg::sign_t osign;

  assign head    = cell_data[0];
  assign in_acc  = in_valid_i && in_ready_o;
  assign emit_go = (state_q == sof_pkg::StEmit) && (!out_valid_q || out_ready_i);

  for (genvar i = 0; i < sof_pkg::SofDepth; i++) begin : g_cell
    sof_pkg::cell_ctl_t ctl;
    sof_pkg::entry_t    nb;
    assign ctl.shift = shift_en;
    assign ctl.load  = load_en && (load_idx == sof_pkg::CntW'(i));
    if (i == sof_pkg::SofDepth - 1) begin : g_tail
      assign nb = '0;
    end else begin : g_mid
      assign nb = cell_data[i+1];
    end
    sof_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .ld_data_i (ld_data),
      .nb_data_i (nb),
      .data_o    (cell_data[i])
    );
  end

  always_comb begin
    if (phase_q[1]) begin
      px = head.ax; py = head.ay; qx = head.bx; qy = head.by;
      rx = phase_q[0] ? seg_q.bx : seg_q.ax;
      ry = phase_q[0] ? seg_q.by : seg_q.ay;
    end else begin
      px = seg_q.ax; py = seg_q.ay; qx = seg_q.bx; qy = seg_q.by;
      rx = phase_q[0] ? head.bx : head.ax;
      ry = phase_q[0] ? head.by : head.ay;
    end
  end

  sof_orient u_orient (
    .clk_i  (clk_i),
    .en_i   (state_q == sof_pkg::StTest),
    .px_i   (px),
    .py_i   (py),
    .qx_i   (qx),
    .qy_i   (qy),
    .rx_i   (rx),
    .ry_i   (ry),
    .sign_o (osign)
  );

  assign all_zero = !sgn_q[0].pos && !sgn_q[0].neg && !sgn_q[1].pos && !sgn_q[1].neg &&
                    !sgn_q[2].pos && !sgn_q[2].neg && !sgn_q[3].pos && !sgn_q[3].neg;
  assign side12 = (sgn_q[0].pos && sgn_q[1].pos) || (sgn_q[0].neg && sgn_q[1].neg);
  assign side34 = (sgn_q[2].pos && sgn_q[3].pos) || (sgn_q[2].neg && sgn_q[3].neg);
  assign touch  = all_zero ?
                  (sof_pkg::ranges_meet(seg_q.ax, seg_q.bx, head.ax, head.bx) &&
                   sof_pkg::ranges_meet(seg_q.ay, seg_q.by, head.ay, head.by)) :
                  (!side12 && !side34);

  always_comb begin
    state_d = state_q;
    case (state_q)
      sof_pkg::StIdle: begin
        if (in_acc) begin
          state_d = (len_q == '0) ? sof_pkg::StAppend : sof_pkg::StTest;
        end
      end
      sof_pkg::StTest: begin
        if (phase_q == sof_pkg::PhaseDecide && rem_q == sof_pkg::CntW'(1)) begin
          state_d = sof_pkg::StAppend;
        end
      end
      sof_pkg::StAppend: begin
        state_d = last_q ? sof_pkg::StEmit : sof_pkg::StIdle;
      end
      sof_pkg::StEmit: begin
        if (emit_go && len_q == sof_pkg::CntW'(1)) begin
          state_d = sof_pkg::StIdle;
        end
      end
      default: state_d = sof_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    shift_en    = 1'b0;
    load_en     = 1'b0;
    load_idx    = len_q;
    ld_data     = seg_q;
    len_d       = len_q;
    rem_d       = rem_q;
    arr_d       = arr_q;
    ovf_d       = ovf_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      sof_pkg::StIdle: begin
        in_ready_o = 1'b1;
        phase_d    = '0;
        rem_d      = len_q;
        if (in_acc && arr_q != sof_pkg::NumMax) begin
          arr_d = arr_q + 1'b1;
        end
      end
      sof_pkg::StTest: begin
        phase_d = phase_q + 1'b1;
        if (phase_q == sof_pkg::PhaseDecide) begin
          phase_d  = '0;
          shift_en = 1'b1;
          rem_d    = rem_q - 1'b1;
          ld_data  = head;
          load_idx = len_q - 1'b1;
          if (touch) begin
            len_d = len_q - 1'b1;
          end else begin
            load_en = 1'b1;
          end
        end
      end
      sof_pkg::StAppend: begin
        if (len_q < sof_pkg::CntW'(sof_pkg::SofDepth)) begin
          load_en = 1'b1;
          len_d   = len_q + 1'b1;
        end else begin
          ovf_d = 1'b1;
        end
      end
      sof_pkg::StEmit: begin
        if (emit_go) begin
          shift_en             = 1'b1;
          out_valid_d          = 1'b1;
          out_d.segment_number = head.num;
          out_d.last_of_run    = (len_q == sof_pkg::CntW'(1));
          out_d.overflow       = ovf_q;
          len_d                = len_q - 1'b1;
          if (len_q == sof_pkg::CntW'(1)) begin
            arr_d = '0;
            ovf_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sof_pkg::StIdle;
      len_q       <= '0;
      rem_q       <= '0;
      arr_q       <= '0;
      ovf_q       <= 1'b0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      rem_q       <= rem_d;
      arr_q       <= arr_d;
      ovf_q       <= ovf_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_acc) begin
      seg_q.ax  <= in_req_i.start_x;
      seg_q.ay  <= in_req_i.start_y;
      seg_q.bx  <= in_req_i.end_x;
      seg_q.by  <= in_req_i.end_y;
      seg_q.num <= (arr_q != sof_pkg::NumMax) ? arr_q + 1'b1 : arr_q;
      last_q    <= in_req_i.last_in_set;
    end
    if (state_q == sof_pkg::StTest && phase_q != '0 && phase_q <= sof_pkg::PhaseLastSign) begin
      sgn_q[phase_q[1:0] - 2'd1] <= osign;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= sof_pkg::CntW'(sof_pkg::SofDepth))
    else $error("kept list longer than the chain");
  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sof_pkg::StEmit |-> len_q != '0)
    else $error("readout with an empty list");
  a_test_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sof_pkg::StTest |-> (rem_q != '0 && rem_q <= len_q))
    else $error("test sweep past the list");
`endif

endmodule
